/* hw/rtl/pfp_pkg.sv */
`timescale 1ns / 1ps
package pfp_pkg;

	localparam int COORD_W    = 24;
	localparam int NORM_W     = 18;
	localparam int DIST_W     = 25;
	localparam int COORD_FRAC = 8;
	localparam int NORM_FRAC  = 16;

	localparam int EDGE_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = PROD_W;
	localparam int POS_W   = $clog2(MAG_W);
	localparam int MANT_W  = 31;
	localparam int SQ_W    = 2 * MANT_W;
	localparam int SUM_W   = 64;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 4;

	localparam int SQRT_STAGES = ROOT_W;
	localparam int QUO_W       = NORM_FRAC + 1;
	localparam int DIV_STAGES  = QUO_W;
	localparam int NUM_W       = MANT_W + QUO_W + 1;
	localparam int DEN_W       = ROOT_W + 1;
	localparam int DREM_W      = NUM_W + 1;

	localparam int FRONT_STAGES = 8;
	localparam int LINE_LEN     = FRONT_STAGES + SQRT_STAGES + DIV_STAGES;
	localparam int MERGE_STAGES = 4;

	localparam int DOT_W = NORM_W + COORD_W + 2;
	localparam int DR_W  = DOT_W - NORM_FRAC;

	localparam int NEPS_W     = 16;
	localparam int DEPS_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = NEPS_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NORMAL_EPS = 1'b0,
		CFG_DIST_EPS   = 1'b1
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;
	typedef logic [QUO_W-1:0]          quo_t;

endpackage

/* hw/rtl/plane_from_three_points_core.sv */
`timescale 1ns / 1ps
// Accepted input words pass through the front stages, the 32-stage square-root
// pipeline, the 17-stage divider lanes and then the merge stages.
// Throughput: one word per cycle; a stalled output holds one word in a skid
// register and input is taken again once it drains.
// Reset: pipeline empties, normal_epsilon returns to 1, distance_epsilon to 3.
module plane_from_three_points_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [pfp_pkg::COORD_W-1:0] p1_x,
	input  logic signed [pfp_pkg::COORD_W-1:0] p1_y,
	input  logic signed [pfp_pkg::COORD_W-1:0] p1_z,
	input  logic signed [pfp_pkg::COORD_W-1:0] p2_x,
	input  logic signed [pfp_pkg::COORD_W-1:0] p2_y,
	input  logic signed [pfp_pkg::COORD_W-1:0] p2_z,
	input  logic signed [pfp_pkg::COORD_W-1:0] p3_x,
	input  logic signed [pfp_pkg::COORD_W-1:0] p3_y,
	input  logic signed [pfp_pkg::COORD_W-1:0] p3_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pfp_pkg::NORM_W-1:0] normal_x,
	output logic signed [pfp_pkg::NORM_W-1:0] normal_y,
	output logic signed [pfp_pkg::NORM_W-1:0] normal_z,
	output logic signed [pfp_pkg::DIST_W-1:0] plane_distance,
	output logic                              degenerate
);
	import pfp_pkg::*;

	localparam int M_FIRST  = 5;
	localparam int M_LAST   = FRONT_STAGES + SQRT_STAGES - 1;
	localparam int F_FIRST  = 3;

	logic [NEPS_W-1:0] norm_eps_q;
	logic [DEPS_W-1:0] dist_eps_q;

	logic en;

	logic                    vld_q [LINE_LEN];
	coord_t                  p1_q  [LINE_LEN][3];
	logic [2:0]              neg_q [F_FIRST:LINE_LEN-1];
	logic                    dgn_q [F_FIRST:LINE_LEN-1];
	logic [MANT_W-1:0]       m_q   [M_FIRST:M_LAST][3];

	logic signed [EDGE_W-1:0]  a_s1 [3];
	logic signed [EDGE_W-1:0]  b_s1 [3];
	logic signed [PROD_W-1:0]  pr_s2 [6];
	logic signed [CROSS_W-1:0] c_s3 [3];
	logic [MAG_W-1:0]          mag_s4 [3];
	logic [MAG_W-1:0]          mag_s5 [3];
	logic [POS_W-1:0]          pos_s5;
	logic [SQ_W-1:0]           sq_s7 [3];
	logic [SUM_W-1:0]          sum_s8;

	logic [ROOT_W-1:0] root;
	quo_t              quo [3];

	logic              mv_q [MERGE_STAGES];
	norm_t             mg_normal [3];
	logic signed [DIST_W-1:0] mg_dist;
	logic              mg_degen;

	logic              skid_v_q;
	norm_t             skid_normal_q [3];
	logic signed [DIST_W-1:0] skid_dist_q;
	logic              skid_degen_q;

	assign en       = !skid_v_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_eps_q <= NEPS_W'(1);
			dist_eps_q <= DEPS_W'(3);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_NORMAL_EPS: norm_eps_q <= cfg_data[NEPS_W-1:0];
				CFG_DIST_EPS:   dist_eps_q <= cfg_data[DEPS_W-1:0];
				default:        ;
			endcase
		end
	end

	// valid line through front, root and divider stages, then merge stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LINE_LEN; k++)
				vld_q[k] <= 1'b0;
			for (int k = 0; k < MERGE_STAGES; k++)
				mv_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < LINE_LEN; k++)
				vld_q[k] <= vld_q[k-1];
			mv_q[0] <= vld_q[LINE_LEN-1];
			for (int k = 1; k < MERGE_STAGES; k++)
				mv_q[k] <= mv_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_q[0][0] <= p1_x;
			p1_q[0][1] <= p1_y;
			p1_q[0][2] <= p1_z;
			for (int k = 1; k < LINE_LEN; k++)
				p1_q[k] <= p1_q[k-1];
		end
	end

	// edges
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= {p2_x[COORD_W-1], p2_x} - {p1_x[COORD_W-1], p1_x};
			a_s1[1] <= {p2_y[COORD_W-1], p2_y} - {p1_y[COORD_W-1], p1_y};
			a_s1[2] <= {p2_z[COORD_W-1], p2_z} - {p1_z[COORD_W-1], p1_z};
			b_s1[0] <= {p3_x[COORD_W-1], p3_x} - {p1_x[COORD_W-1], p1_x};
			b_s1[1] <= {p3_y[COORD_W-1], p3_y} - {p1_y[COORD_W-1], p1_y};
			b_s1[2] <= {p3_z[COORD_W-1], p3_z} - {p1_z[COORD_W-1], p1_z};
		end
	end

	// cross product terms
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2[0] <= a_s1[1] * b_s1[2];
			pr_s2[1] <= a_s1[2] * b_s1[1];
			pr_s2[2] <= a_s1[2] * b_s1[0];
			pr_s2[3] <= a_s1[0] * b_s1[2];
			pr_s2[4] <= a_s1[0] * b_s1[1];
			pr_s2[5] <= a_s1[1] * b_s1[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				c_s3[j] <= CROSS_W'(pr_s2[2*j]) - CROSS_W'(pr_s2[2*j+1]);
		end
	end

	// magnitudes, signs, zero test
	always_ff @(posedge clk) begin
		logic [CROSS_W-1:0] t;
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				t = c_s3[j][CROSS_W-1] ? CROSS_W'(-c_s3[j]) : CROSS_W'(c_s3[j]);
				mag_s4[j]        <= t[MAG_W-1:0];
				neg_q[F_FIRST][j] <= c_s3[j][CROSS_W-1];
			end
			dgn_q[F_FIRST] <= (c_s3[0] == '0) && (c_s3[1] == '0) && (c_s3[2] == '0);
			for (int k = F_FIRST + 1; k < LINE_LEN; k++) begin
				neg_q[k] <= neg_q[k-1];
				dgn_q[k] <= dgn_q[k-1];
			end
		end
	end

	// leading one of the largest magnitude
	always_ff @(posedge clk) begin
		logic [MAG_W-1:0] any;
		logic [POS_W-1:0] pos;
		if (en) begin
			any = mag_s4[0] | mag_s4[1] | mag_s4[2];
			pos = '0;
			for (int i = 0; i < MAG_W; i++)
				if (any[i])
					pos = POS_W'(i);
			pos_s5 <= pos;
			for (int j = 0; j < 3; j++)
				mag_s5[j] <= mag_s4[j];
		end
	end

	// common shift puts the largest magnitude's msb at the top mantissa bit
	always_ff @(posedge clk) begin
		logic [MAG_W+MANT_W-2:0] w;
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				w = {mag_s5[j], {(MANT_W - 1){1'b0}}} >> pos_s5;
				m_q[M_FIRST][j] <= w[MANT_W-1:0];
			end
			for (int k = M_FIRST + 1; k <= M_LAST; k++)
				m_q[k] <= m_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				sq_s7[j] <= m_q[M_FIRST][j] * m_q[M_FIRST][j];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			sum_s8 <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
	end

	pfp_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s8),
		.root     (root)
	);

	for (genvar j = 0; j < 3; j++) begin : g_lane
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		assign num = NUM_W'({m_q[M_LAST][j], {QUO_W{1'b0}}}) + NUM_W'(root);
		assign den = {root, 1'b0};
		pfp_div_lane u_div (
			.clk (clk),
			.en  (en),
			.num (num),
			.den (den),
			.quo (quo[j])
		);
	end

	pfp_merge u_merge (
		.clk        (clk),
		.en         (en),
		.quo        (quo),
		.neg        (neg_q[LINE_LEN-1]),
		.degen_in   (dgn_q[LINE_LEN-1]),
		.p1         (p1_q[LINE_LEN-1]),
		.norm_eps   (norm_eps_q),
		.dist_eps   (dist_eps_q),
		.normal     (mg_normal),
		.plane_dist (mg_dist),
		.degen_out  (mg_degen)
	);

	// skid: hold a word that the sink refused, freeze the pipe behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready)
				skid_v_q <= 1'b0;
		end else if (mv_q[MERGE_STAGES-1] && !out_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_normal_q <= mg_normal;
			skid_dist_q   <= mg_dist;
			skid_degen_q  <= mg_degen;
		end
	end

	assign out_valid      = skid_v_q || mv_q[MERGE_STAGES-1];
	assign normal_x       = skid_v_q ? skid_normal_q[0] : mg_normal[0];
	assign normal_y       = skid_v_q ? skid_normal_q[1] : mg_normal[1];
	assign normal_z       = skid_v_q ? skid_normal_q[2] : mg_normal[2];
	assign plane_distance = skid_v_q ? skid_dist_q : mg_dist;
	assign degenerate     = skid_v_q ? skid_degen_q : mg_degen;

endmodule

/* hw/rtl/pfp_sqrt.sv */
`timescale 1ns / 1ps
module pfp_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [pfp_pkg::SUM_W-1:0]   radicand,
	output logic [pfp_pkg::ROOT_W-1:0]  root
);
	import pfp_pkg::*;

	logic [SUM_W-1:0]  rad_s  [1:SQRT_STAGES];
	logic [REM_W-1:0]  rem_s  [1:SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [1:SQRT_STAGES];

	// one root bit per stage, two radicand bits shifted in
	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic [SUM_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W-1:0]  cur;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (g == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[g];
			assign rem_in  = rem_s[g];
			assign root_in = root_s[g];
		end

		assign cur   = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
		assign trial = REM_W'({root_in, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1]  <= {rad_in[SUM_W-3:0], 2'b00};
				rem_s[g+1]  <= ge ? (cur - trial) : cur;
				root_s[g+1] <= {root_in[ROOT_W-2:0], ge};
			end
		end
	end

	assign root = root_s[SQRT_STAGES];

endmodule

/* hw/rtl/pfp_div_lane.sv */
`timescale 1ns / 1ps
module pfp_div_lane (
	input  logic                       clk,
	input  logic                       en,
	input  logic [pfp_pkg::NUM_W-1:0]  num,
	input  logic [pfp_pkg::DEN_W-1:0]  den,
	output logic [pfp_pkg::QUO_W-1:0]  quo
);
	import pfp_pkg::*;

	logic [DREM_W-1:0] rem_s [1:DIV_STAGES];
	logic [DEN_W-1:0]  den_s [1:DIV_STAGES];
	logic [QUO_W-1:0]  quo_s [1:DIV_STAGES];

	// restoring division, quotient msb first
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DREM_W-1:0] rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [QUO_W-1:0]  quo_in;
		logic [DREM_W-1:0] shd;
		logic              ge;

		if (g == 0) begin : g_first
			assign rem_in = DREM_W'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[g];
			assign den_in = den_s[g];
			assign quo_in = quo_s[g];
		end

		assign shd = DREM_W'(den_in) << (DIV_STAGES - 1 - g);
		assign ge  = (rem_in >= shd);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? (rem_in - shd) : rem_in;
				den_s[g+1] <= den_in;
				quo_s[g+1] <= {quo_in[QUO_W-2:0], ge};
			end
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule

/* hw/rtl/pfp_merge.sv */
`timescale 1ns / 1ps
module pfp_merge (
	input  logic                          clk,
	input  logic                          en,
	input  pfp_pkg::quo_t                 quo [3],
	input  logic [2:0]                    neg,
	input  logic                          degen_in,
	input  pfp_pkg::coord_t               p1 [3],
	input  logic [pfp_pkg::NEPS_W-1:0]    norm_eps,
	input  logic [pfp_pkg::DEPS_W-1:0]    dist_eps,
	output pfp_pkg::norm_t                normal [3],
	output logic signed [pfp_pkg::DIST_W-1:0] plane_dist,
	output logic                          degen_out
);
	import pfp_pkg::*;

	localparam logic [QUO_W-1:0]        ONE_Q   = QUO_W'(1) << NORM_FRAC;
	localparam logic signed [NORM_W:0]  ONE_X   = (NORM_W + 1)'(1) << NORM_FRAC;
	localparam norm_t                   ONE_N   = NORM_W'(1) << NORM_FRAC;
	localparam logic signed [DOT_W-1:0] HALF_N  = DOT_W'(1) << (NORM_FRAC - 1);
	localparam logic signed [DR_W:0]    HALF_C  = (DR_W + 1)'(1) << (COORD_FRAC - 1);
	localparam logic signed [DR_W:0]    D_MAX   = (DR_W + 1)'((1 << (DIST_W - 1)) - 1);
	localparam logic signed [DR_W:0]    D_MIN   = -((DR_W + 1)'(1) << (DIST_W - 1));

	localparam int PDOT_W = NORM_W + COORD_W;

	norm_t                    n_s1 [3];
	coord_t                   p1_s1 [3];
	logic                     degen_s1;
	norm_t                    n_s2 [3];
	logic signed [PDOT_W-1:0] pr_s2 [3];
	logic                     degen_s2;
	norm_t                    n_s3 [3];
	logic signed [DR_W-1:0]   d_s3;
	logic                     degen_s3;

	norm_t                    n_nx [3];
	logic signed [DR_W:0]     d_nx;

	// clamp and sign each lane's quotient
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				n_s1[j]  <= neg[j] ? -NORM_W'((quo[j] > ONE_Q) ? ONE_Q : quo[j])
				                   :  NORM_W'((quo[j] > ONE_Q) ? ONE_Q : quo[j]);
				p1_s1[j] <= p1[j];
			end
			degen_s1 <= degen_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pr_s2[j] <= n_s1[j] * p1_s1[j];
				n_s2[j]  <= n_s1[j];
			end
			degen_s2 <= degen_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [DOT_W-1:0] acc;
		if (en) begin
			acc = DOT_W'(pr_s2[0]) + DOT_W'(pr_s2[1]) + DOT_W'(pr_s2[2]) + HALF_N;
			d_s3 <= acc[DOT_W-1:NORM_FRAC];
			for (int j = 0; j < 3; j++)
				n_s3[j] <= n_s2[j];
			degen_s3 <= degen_s2;
		end
	end

	// snap the normal to an axis, then snap the distance to the integer grid and clamp it
	always_comb begin
		logic signed [NORM_W:0]  nx;
		logic signed [NORM_W:0]  dp;
		logic signed [NORM_W:0]  dm;
		logic [NORM_W:0]         ap;
		logic [NORM_W:0]         am;
		logic                    hit;
		logic signed [DR_W:0]    dd;
		logic signed [DR_W:0]    t;
		logic signed [DR_W:0]    grid;
		logic signed [DR_W:0]    diff;
		logic [DR_W:0]           adiff;
		for (int j = 0; j < 3; j++)
			n_nx[j] = n_s3[j];
		hit = 1'b0;
		for (int j = 0; j < 3; j++) begin
			nx = (NORM_W + 1)'(n_s3[j]);
			dp = nx - ONE_X;
			dm = nx + ONE_X;
			ap = dp[NORM_W] ? (NORM_W + 1)'(-dp) : (NORM_W + 1)'(dp);
			am = dm[NORM_W] ? (NORM_W + 1)'(-dm) : (NORM_W + 1)'(dm);
			if (!hit) begin
				if (ap < (NORM_W + 1)'(norm_eps)) begin
					hit = 1'b1;
					for (int k = 0; k < 3; k++)
						n_nx[k] = '0;
					n_nx[j] = ONE_N;
				end else if (am < (NORM_W + 1)'(norm_eps)) begin
					hit = 1'b1;
					for (int k = 0; k < 3; k++)
						n_nx[k] = '0;
					n_nx[j] = -ONE_N;
				end
			end
		end

		dd    = (DR_W + 1)'(d_s3);
		t     = dd + HALF_C;
		grid  = {t[DR_W:COORD_FRAC], {COORD_FRAC{1'b0}}};
		diff  = dd - grid;
		adiff = diff[DR_W] ? (DR_W + 1)'(-diff) : (DR_W + 1)'(diff);
		if (adiff < (DR_W + 1)'(dist_eps))
			dd = grid;
		if (dd > D_MAX)
			dd = D_MAX;
		if (dd < D_MIN)
			dd = D_MIN;
		d_nx = dd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				normal[j] <= degen_s3 ? '0 : n_nx[j];
			plane_dist <= degen_s3 ? '0 : d_nx[DIST_W-1:0];
			degen_out  <= degen_s3;
		end
	end

endmodule
